// ----- design/mppl_pkg.sv -----
// Package for the memory pressure adaptive poller.
// Holds register indexes, interval and memory limits, state machine and record types.
// No dependencies.
`default_nettype none

package mppl_pkg;

   localparam int THR_W   = 21;
   localparam int IVL_W   = 20;
   localparam int MB_W    = 32;
   localparam int CNT_W   = 32;
   localparam int CSR_A_W = 3;

   localparam logic [THR_W-1:0] MAX_MEM_MB  = 21'd1048576;
   localparam logic [IVL_W-1:0] MIN_POLL_MS = 20'd500;
   localparam logic [IVL_W-1:0] MAX_POLL_MS = 20'd600000;

   localparam logic [THR_W-1:0] PHYS_THR_RST   = 21'd1024;
   localparam logic [THR_W-1:0] RAMP_WIN_RST   = 21'd1024;
   localparam logic [THR_W-1:0] COMMIT_THR_RST = 21'd0;
   localparam logic [IVL_W-1:0] MIN_IVL_RST    = 20'd500;
   localparam logic [IVL_W-1:0] MAX_IVL_RST    = 20'd3000;

   localparam logic [CSR_A_W-1:0] CSR_PHYS_THR   = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_RAMP_WIN   = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_COMMIT_THR = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_MIN_IVL    = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_MAX_IVL    = 3'd4;

   // Step counts of the bit-serial ramp unit
   localparam logic [4:0] SQ_STEPS  = 5'd21;
   localparam logic [4:0] MUL_STEPS = 5'd20;
   localparam logic [4:0] DIV_STEPS = 5'd20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } mppl_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SQUARE,
      PH_MULT,
      PH_LOAD,
      PH_DIV,
      PH_DONE
   } mppl_phase_type;

   // Operands of one ramp evaluation: offset above threshold, window, interval span
   typedef struct packed {
      logic [IVL_W-1:0] x;
      logic [THR_W-1:0] win;
      logic [IVL_W-1:0] span;
   } mppl_ramp_op_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             recovered;
      logic             report;
      logic             unload;
      logic             entered;
      logic             commit_low;
      logic             phys_low;
      logic             pressure;
   } mppl_flags_type;

endpackage

`default_nettype wire

// ----- design/mppl_ramp.sv -----
// Bit-serial ramp unit: span * x^2 / win^2, one bit per cycle per phase.
// Squares, multiply and restoring divide each use their own shift registers; uses mppl_pkg.
`default_nettype none

module mppl_ramp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mppl_pkg::mppl_ramp_op_type op,
   output logic                       done,
   output logic [19:0]                quot
);
   import mppl_pkg::*;

   mppl_phase_type phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [20:0] x_ff, win_ff;
   logic [20:0] xsh_ff, wsh_ff;
   logic [19:0] ssh_ff;
   logic [39:0] xsq_ff, xsq_in;
   logic [40:0] wsq_ff, wsq_in;
   logic [59:0] prod_ff, prod_in;
   logic [40:0] rem_ff, rem_in;
   logic [19:0] nsh_ff;
   logic [19:0] quot_ff;
   logic [41:0] trial, diff;
   logic        ge;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:   if (start) phase_in = PH_SQUARE;
         PH_SQUARE: if (cnt_ff == SQ_STEPS - 5'd1) phase_in = PH_MULT;
         PH_MULT:   if (cnt_ff == MUL_STEPS - 5'd1) phase_in = PH_LOAD;
         PH_LOAD:   phase_in = PH_DIV;
         PH_DIV:    if (cnt_ff == DIV_STEPS - 5'd1) phase_in = PH_DONE;
         PH_DONE:   phase_in = PH_IDLE;
         default:   phase_in = PH_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (phase_ff == PH_DONE);
      quot = quot_ff;
   end

   // shift-add and shift-subtract steps
   always_comb begin
      cnt_in = (phase_in != phase_ff) ? 5'd0 : cnt_ff + 5'd1;
      xsq_in = {xsq_ff[38:0], 1'b0} + (xsh_ff[20] ? {19'd0, x_ff} : 40'd0);
      wsq_in = {wsq_ff[39:0], 1'b0} + (wsh_ff[20] ? {20'd0, win_ff} : 41'd0);
      prod_in = {prod_ff[58:0], 1'b0} + (ssh_ff[19] ? {20'd0, xsq_ff} : 60'd0);
      trial = {rem_ff, nsh_ff[19]};
      diff = trial - {1'b0, wsq_ff};
      ge = (trial >= {1'b0, wsq_ff});
      rem_in = ge ? diff[40:0] : trial[40:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               x_ff <= {1'b0, op.x};
               xsh_ff <= {1'b0, op.x};
               win_ff <= op.win;
               wsh_ff <= op.win;
               ssh_ff <= op.span;
               xsq_ff <= '0;
               wsq_ff <= '0;
               prod_ff <= '0;
            end
         end
         PH_SQUARE: begin
            xsq_ff <= xsq_in;
            wsq_ff <= wsq_in;
            xsh_ff <= {xsh_ff[19:0], 1'b0};
            wsh_ff <= {wsh_ff[19:0], 1'b0};
         end
         PH_MULT: begin
            prod_ff <= prod_in;
            ssh_ff <= {ssh_ff[18:0], 1'b0};
         end
         PH_LOAD: begin
            // quotient fits 20 bits, so the top 40 bits are already below the divisor
            rem_ff <= {1'b0, prod_ff[59:20]};
            nsh_ff <= prod_ff[19:0];
         end
         PH_DIV: begin
            rem_ff <= rem_in;
            nsh_ff <= {nsh_ff[18:0], 1'b0};
            quot_ff <= {quot_ff[18:0], ge};
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_off_below_win: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SQUARE |-> x_ff < win_ff)
      else $error("ramp offset not below window");
   a_sq_order: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MULT |-> {1'b0, xsq_ff} < wsq_ff)
      else $error("offset square not below window square");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIV |-> rem_ff < wsq_ff)
      else $error("partial remainder out of range");
`endif

endmodule

`default_nettype wire

// ----- design/memory_pressure_adaptive_poller.sv -----
// Top level of the memory pressure adaptive poller.
// Pressure tracking, config registers and result register; uses mppl_pkg and mppl_ramp.
//
// Usage:
//  - req channel: one memory sample per transfer. req_tuser is sample_ok,
//    req_tdata holds avail_phys_mb [31:0] and avail_commit_mb [63:32].
//  - rsp channel: exactly one result per sample, in order.
//  - csr channel: register index on csr_addr, value on csr_wdata; always ready.
//    Write only while no sample is in flight.
//  - After acceptance, a minimum or maximum interval goes through the finish
//    state into the output register; one on the quadratic ramp first passes
//    through squaring, multiply, remainder load, restoring divide and the
//    done phase, then the finish state and the output register.
//  - One sample at a time: the next is taken once the previous one has moved
//    into the output register.
//  - The output register holds a result while rsp_tready is low; a new sample
//    may be accepted and computed meanwhile, and waits for the register.
//  - Reset (synchronous) clears pressure, the report latch, the event count,
//    the output valid flag, returns to idle and loads the default configuration.
`default_nettype none

module memory_pressure_adaptive_poller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // avail_phys_mb[31:0], avail_commit_mb[63:32]
   input  logic        req_tuser,   // sample_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // interval_ms[19:0], pressure_now[20], phys_is_low[21],
                                    // commit_is_low[22], entered_pressure[23],
                                    // request_unload[24], request_report[25],
                                    // recovered[26], event_count[58:27], zero[63:59]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [20:0] csr_wdata
);
   import mppl_pkg::*;

   mppl_state_type state_ff, state_in;

   logic [THR_W-1:0] phys_thr_ff, ramp_win_ff, commit_thr_ff;
   logic [IVL_W-1:0] min_ivl_ff, max_ivl_ff;

   logic             press_ff, saved_ff;
   logic [CNT_W-1:0] count_ff;

   mppl_flags_type   res_ff, res_in;
   logic [IVL_W-1:0] ivl_ff;

   logic             rsp_tvalid_ff;
   mppl_flags_type   out_res_ff;
   logic [IVL_W-1:0] out_ivl_ff;

   logic             req_fire, out_free, load_out;
   logic [MB_W-1:0]  phys, commit;
   logic             valid, low, press_in;
   logic [THR_W-1:0] eff_thr, eff_win;
   logic [IVL_W-1:0] eff_min, eff_max;
   logic [THR_W:0]   thr_plus_win;
   logic             use_ramp, ramp_start, ramp_done;
   logic [IVL_W-1:0] ramp_quot;
   mppl_ramp_op_type ramp_op;

   assign phys   = req_tdata[31:0];
   assign commit = req_tdata[63:32];
   assign valid  = req_tuser;

   // effective configuration
   always_comb begin
      eff_thr = (phys_thr_ff > MAX_MEM_MB) ? MAX_MEM_MB : phys_thr_ff;
      eff_win = (ramp_win_ff > MAX_MEM_MB) ? MAX_MEM_MB : ramp_win_ff;
      if (min_ivl_ff < MIN_POLL_MS) eff_min = MIN_POLL_MS;
      else if (min_ivl_ff > MAX_POLL_MS) eff_min = MAX_POLL_MS;
      else eff_min = min_ivl_ff;
      if (max_ivl_ff < eff_min) eff_max = eff_min;
      else if (max_ivl_ff > MAX_POLL_MS) eff_max = MAX_POLL_MS;
      else eff_max = max_ivl_ff;
      thr_plus_win = {1'b0, eff_thr} + {1'b0, eff_win};
   end

   // sample evaluation
   always_comb begin
      res_in.phys_low = valid && (eff_thr != '0) && (phys <= {11'd0, eff_thr});
      res_in.commit_low = valid && (commit_thr_ff != '0) && (commit <= {11'd0, commit_thr_ff});
      low = res_in.phys_low || res_in.commit_low;
      press_in = valid ? low : press_ff;
      res_in.pressure = press_in;
      res_in.entered = valid && low && !press_ff;
      res_in.report = valid && low && !saved_ff;
      res_in.unload = valid && low;
      res_in.recovered = valid && !low && press_ff;
      res_in.count = count_ff + {{(CNT_W-1){1'b0}}, res_in.entered};
      use_ramp = !press_in && valid && (eff_thr != '0) && (eff_win != '0)
                 && (phys > {11'd0, eff_thr}) && (phys < {10'd0, thr_plus_win});
      ramp_op.x = phys[IVL_W-1:0] - eff_thr[IVL_W-1:0];
      ramp_op.win = eff_win;
      ramp_op.span = eff_max - eff_min;
   end

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = use_ramp ? ST_CALC : ST_FINISH;
         ST_CALC:   if (ramp_done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      ramp_start = (state_ff == ST_IDLE) && req_tvalid && use_ramp;
      load_out = (state_ff == ST_FINISH) && out_free;
   end

   mppl_ramp u_ramp (
      .clock (clock),
      .reset (reset),
      .start (ramp_start),
      .op    (ramp_op),
      .done  (ramp_done),
      .quot  (ramp_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         press_ff <= 1'b0;
         saved_ff <= 1'b0;
         count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
         phys_thr_ff <= PHYS_THR_RST;
         ramp_win_ff <= RAMP_WIN_RST;
         commit_thr_ff <= COMMIT_THR_RST;
         min_ivl_ff <= MIN_IVL_RST;
         max_ivl_ff <= MAX_IVL_RST;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            press_ff <= press_in;
            // report latch is armed on a healthy sample, set on a low one
            if (valid) saved_ff <= low;
            count_ff <= res_in.count;
         end
         if (load_out) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_addr)
               CSR_PHYS_THR:   phys_thr_ff <= csr_wdata;
               CSR_RAMP_WIN:   ramp_win_ff <= csr_wdata;
               CSR_COMMIT_THR: commit_thr_ff <= csr_wdata;
               CSR_MIN_IVL:    min_ivl_ff <= csr_wdata[IVL_W-1:0];
               CSR_MAX_IVL:    max_ivl_ff <= csr_wdata[IVL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         res_ff <= res_in;
         ivl_ff <= press_in ? eff_min : eff_max;
      end else if (state_ff == ST_CALC && ramp_done) begin
         ivl_ff <= eff_min + ramp_quot;
      end
      if (load_out) begin
         out_res_ff <= res_ff;
         out_ivl_ff <= ivl_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'd0, out_res_ff, out_ivl_ff};

`ifndef SYNTHESIS
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      ramp_done |-> state_ff == ST_CALC)
      else $error("ramp result outside calc state");
   a_latch_tracks: assert property (@(posedge clock) disable iff (reset)
      saved_ff == press_ff)
      else $error("report latch out of step with pressure");
   a_entry_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && out_res_ff.entered |-> out_res_ff.pressure)
      else $error("pressure entry without pressure");
   a_recov_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && out_res_ff.recovered |-> !out_res_ff.pressure && !out_res_ff.unload)
      else $error("recovery while pressured");
`endif

endmodule

`default_nettype wire
